@@ src/event_subscription_table_macros.svh @@
// ----------------------------------------------------------------------------
// event subscription table assertion macros
// concurrent check helpers used by the checker file est_checker
// ----------------------------------------------------------------------------
`ifndef EVENT_SUBSCRIPTION_TABLE_MACROS_SVH
`define EVENT_SUBSCRIPTION_TABLE_MACROS_SVH

// same-cycle implication
`define EST_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("event subscription table check failed");

// next-cycle implication
`define EST_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("event subscription table check failed");

`endif

@@ src/est_pkg.sv @@
// ----------------------------------------------------------------------------
// est_pkg
// shared constants, codes and types of the event subscription table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package est_pkg;

	localparam int SLOTS     = 64;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int OP_W      = 3;
	localparam int TYPE_W    = 16;
	localparam int HANDLER_W = 16;
	localparam int SLOT_IN_W = 6;
	localparam int STATUS_W  = 2;
	localparam int SLOT_OUT_W = 6;

	localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
	localparam logic [OP_W-1:0] OP_ENABLE   = 3'd2;
	localparam logic [OP_W-1:0] OP_DISABLE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DISPATCH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [TYPE_W-1:0]    ev_type;
		logic [HANDLER_W-1:0] handler;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] idx;
		logic              valid;
		logic              enabled;
	} flag_cmd_t;

endpackage

@@ src/est_ram.sv @@
// ----------------------------------------------------------------------------
// est_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module est_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/est_flags.sv @@
// ----------------------------------------------------------------------------
// est_flags
// valid and enable marks of every slot, cleared at reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module est_flags (
	input  logic                          clk,
	input  logic                          arst_n,
	input  est_pkg::flag_cmd_t            cmd,
	input  logic [est_pkg::SLOT_W-1:0]    rd_idx,
	output logic                          rd_valid,
	output logic                          rd_enabled
);

	logic [est_pkg::SLOTS-1:0] valid_q;
	logic [est_pkg::SLOTS-1:0] enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			enabled_q <= '0;
		end else if (cmd.we) begin
			valid_q[cmd.idx]   <= cmd.valid;
			enabled_q[cmd.idx] <= cmd.enabled;
		end
	end

	assign rd_valid   = valid_q[rd_idx];
	assign rd_enabled = enabled_q[rd_idx];

endmodule

@@ src/est_ctrl.sv @@
// ----------------------------------------------------------------------------
// est_ctrl
// operation sequencer with the shared slot scan and type compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module est_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [est_pkg::OP_W-1:0]           operation,
	input  logic [est_pkg::TYPE_W-1:0]         event_type,
	input  logic [est_pkg::HANDLER_W-1:0]      handler_id,
	input  logic [est_pkg::SLOT_IN_W-1:0]      slot_in,
	output est_pkg::flag_cmd_t                 flag_cmd,
	output logic [est_pkg::SLOT_W-1:0]         flag_rd_idx,
	input  logic                               flag_valid,
	input  logic                               flag_enabled,
	output logic                               ram_we,
	output logic [est_pkg::SLOT_W-1:0]         ram_waddr,
	output est_pkg::entry_t                    ram_wdata,
	output logic [est_pkg::SLOT_W-1:0]         ram_raddr,
	input  est_pkg::entry_t                    ram_rdata,
	output logic                               strobe,
	output logic [est_pkg::STATUS_W-1:0]       status,
	output logic [est_pkg::SLOT_OUT_W-1:0]     slot_out,
	output logic [est_pkg::HANDLER_W-1:0]      handler_out,
	output logic                               last
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_REG   = 2'd1;
	localparam logic [1:0] S_DISP  = 2'd2;
	localparam logic [1:0] S_DRAIN = 2'd3;

	logic [1:0]                        state_q, state_d;
	logic [est_pkg::SLOT_W-1:0]        idx_q, idx_d;
	logic                              fin_q, fin_d;
	logic [est_pkg::TYPE_W-1:0]        type_q;
	logic [est_pkg::HANDLER_W-1:0]     handler_q;

	logic                              vld_s1;
	logic                              cand_s1;
	logic [est_pkg::SLOT_W-1:0]        idx_s1;

	logic                              pend_q, pend_d;
	logic [est_pkg::SLOT_W-1:0]        pend_slot_q, pend_slot_d;
	logic [est_pkg::HANDLER_W-1:0]     pend_handler_q, pend_handler_d;

	logic                              emit;
	logic [est_pkg::STATUS_W-1:0]      emit_status;
	logic [est_pkg::SLOT_OUT_W-1:0]    emit_slot;
	logic [est_pkg::HANDLER_W-1:0]     emit_handler;
	logic                              emit_last;

	logic                              accept;
	logic                              slot_ok;
	logic                              match_s1;
	logic                              scan_end;

	assign busy     = (state_q != S_IDLE) || fin_q;
	assign accept   = start && !busy;
	assign slot_ok  = (32'(slot_in) < 32'(est_pkg::SLOTS)) && flag_valid;
	assign match_s1 = vld_s1 && cand_s1 && (ram_rdata.ev_type == type_q);
	assign scan_end = (idx_q == est_pkg::SLOT_W'(est_pkg::SLOTS - 1));

	assign flag_rd_idx = (state_q == S_IDLE) ? est_pkg::SLOT_W'(slot_in) : idx_q;
	assign ram_raddr   = idx_q;
	assign ram_waddr   = idx_q;
	assign ram_wdata   = '{ev_type: type_q, handler: handler_q};

	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		fin_d          = 1'b0;
		pend_d         = pend_q;
		pend_slot_d    = pend_slot_q;
		pend_handler_d = pend_handler_q;
		flag_cmd       = '0;
		ram_we         = 1'b0;
		emit           = 1'b0;
		emit_status    = est_pkg::ST_OK;
		emit_slot      = '0;
		emit_handler   = '0;
		emit_last      = 1'b0;

		// compare stage: a new match pushes out the one held before it
		if (match_s1) begin
			if (pend_q) begin
				emit         = 1'b1;
				emit_slot    = est_pkg::SLOT_OUT_W'(pend_slot_q);
				emit_handler = pend_handler_q;
			end
			pend_d         = 1'b1;
			pend_slot_d    = idx_s1;
			pend_handler_d = ram_rdata.handler;
		end

		unique case (state_q)
			S_IDLE: begin
				if (fin_q) begin
					// end of a dispatch: flush the held match or report none
					emit      = 1'b1;
					emit_last = 1'b1;
					if (pend_q) begin
						emit_slot    = est_pkg::SLOT_OUT_W'(pend_slot_q);
						emit_handler = pend_handler_q;
					end else begin
						emit_status = est_pkg::ST_NOMATCH;
					end
				end
				if (accept) begin
					priority if (operation == est_pkg::OP_REGISTER) begin
						state_d = S_REG;
						idx_d   = '0;
					end else if (operation == est_pkg::OP_DELETE ||
							operation == est_pkg::OP_ENABLE ||
							operation == est_pkg::OP_DISABLE) begin
						emit        = 1'b1;
						emit_last   = 1'b1;
						emit_slot   = slot_in;
						emit_status = slot_ok ? est_pkg::ST_OK : est_pkg::ST_UNKNOWN;
						if (slot_ok) begin
							flag_cmd.we      = 1'b1;
							flag_cmd.idx     = flag_rd_idx;
							flag_cmd.valid   = (operation != est_pkg::OP_DELETE);
							flag_cmd.enabled = (operation == est_pkg::OP_ENABLE);
						end
					end else if (operation == est_pkg::OP_DISPATCH) begin
						state_d = S_DISP;
						idx_d   = '0;
						pend_d  = 1'b0;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_REG: begin
				if (!flag_valid) begin
					ram_we           = 1'b1;
					flag_cmd.we      = 1'b1;
					flag_cmd.idx     = idx_q;
					flag_cmd.valid   = 1'b1;
					flag_cmd.enabled = 1'b1;
					emit             = 1'b1;
					emit_last        = 1'b1;
					emit_slot        = est_pkg::SLOT_OUT_W'(idx_q);
					state_d          = S_IDLE;
				end else if (scan_end) begin
					emit        = 1'b1;
					emit_last   = 1'b1;
					emit_status = est_pkg::ST_FULL;
					state_d     = S_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DISP: begin
				if (scan_end) begin
					state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
				fin_d   = 1'b1;
			end
		endcase
	end

	// dispatch flush happens in the first idle cycle, before any new accept lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			vld_s1  <= 1'b0;
			pend_q  <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fin_q   <= fin_d;
			vld_s1  <= (state_q == S_DISP);
			pend_q  <= pend_d;
			strobe  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q    <= event_type;
			handler_q <= handler_id;
		end
		cand_s1        <= flag_valid && flag_enabled;
		idx_s1         <= idx_q;
		pend_slot_q    <= pend_slot_d;
		pend_handler_q <= pend_handler_d;
		status         <= emit_status;
		slot_out       <= emit_slot;
		handler_out    <= emit_handler;
		last           <= emit_last;
	end

endmodule

@@ src/event_subscription_table.sv @@
// ----------------------------------------------------------------------------
// event_subscription_table
// subscription table with register, delete, enable, disable and dispatch
// ----------------------------------------------------------------------------
// channel   handshake              payload
// input     start & !busy          operation, event_type, handler_id, slot_in
// result    strobe (one cycle)     status, slot_out, handler_out, last
//
// delete, enable, disable: result in the cycle after the transfer, busy stays low
// register: scans valid marks one slot a cycle until a free slot or the last slot
// dispatch: one slot a cycle through the entry ram and the type compare,
//   results during the scan, the last one after it
// reset clears all marks at once; entry ram holds no reset value
// results cannot be held off by the receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_subscription_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [est_pkg::OP_W-1:0]           operation,
	input  logic [est_pkg::TYPE_W-1:0]         event_type,
	input  logic [est_pkg::HANDLER_W-1:0]      handler_id,
	input  logic [est_pkg::SLOT_IN_W-1:0]      slot_in,
	output logic                               strobe,
	output logic [est_pkg::STATUS_W-1:0]       status,
	output logic [est_pkg::SLOT_OUT_W-1:0]     slot_out,
	output logic [est_pkg::HANDLER_W-1:0]      handler_out,
	output logic                               last
);

	est_pkg::flag_cmd_t             flag_cmd;
	logic [est_pkg::SLOT_W-1:0]     flag_rd_idx;
	logic                           flag_valid;
	logic                           flag_enabled;
	logic                           ram_we;
	logic [est_pkg::SLOT_W-1:0]     ram_waddr;
	logic [est_pkg::SLOT_W-1:0]     ram_raddr;
	est_pkg::entry_t                ram_wdata;
	est_pkg::entry_t                ram_rdata;

	est_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.event_type   (event_type),
		.handler_id   (handler_id),
		.slot_in      (slot_in),
		.flag_cmd     (flag_cmd),
		.flag_rd_idx  (flag_rd_idx),
		.flag_valid   (flag_valid),
		.flag_enabled (flag_enabled),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.strobe       (strobe),
		.status       (status),
		.slot_out     (slot_out),
		.handler_out  (handler_out),
		.last         (last)
	);

	est_flags u_flags (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (flag_cmd),
		.rd_idx     (flag_rd_idx),
		.rd_valid   (flag_valid),
		.rd_enabled (flag_enabled)
	);

	est_ram #(
		.WIDTH (est_pkg::ENTRY_W),
		.DEPTH (est_pkg::SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ src/est_checker.sv @@
// ----------------------------------------------------------------------------
// est_checker
// port level checks of the event subscription table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "event_subscription_table_macros.svh"

module est_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [est_pkg::OP_W-1:0]           operation,
	input logic [est_pkg::TYPE_W-1:0]         event_type,
	input logic [est_pkg::HANDLER_W-1:0]      handler_id,
	input logic [est_pkg::SLOT_IN_W-1:0]      slot_in,
	input logic                               strobe,
	input logic [est_pkg::STATUS_W-1:0]       status,
	input logic [est_pkg::SLOT_OUT_W-1:0]     slot_out,
	input logic [est_pkg::HANDLER_W-1:0]      handler_out,
	input logic                               last
);

	`EST_ASSERT_NEXT(a_slot_op_result, start && !busy && (operation == est_pkg::OP_DELETE || operation == est_pkg::OP_ENABLE || operation == est_pkg::OP_DISABLE), strobe && last)

	`EST_ASSERT_NOW(a_error_is_last, strobe && status != est_pkg::ST_OK, last)

	`EST_ASSERT_NOW(a_nomatch_clean, strobe && status == est_pkg::ST_NOMATCH, slot_out == '0 && handler_out == '0)

	`EST_ASSERT_NEXT(a_dispatch_busy, start && !busy && operation == est_pkg::OP_DISPATCH, busy && !strobe)

endmodule

bind event_subscription_table est_checker u_est_checker (.*);

@@ dv/event_subscription_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_subscription_table_tb
// drives register, delete, enable, disable and dispatch commands through the
// start/busy port with random gaps except in a gapless middle stretch, keeps
// a shadow copy of the subscription table to predict every strobed result
// and compares it field by field

module event_subscription_table_tb;
	import est_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = SLOTS + 8;
	localparam int IDLE_PCT       = 21;
	localparam int RESET_CYCLES   = 9;
	localparam int MAX_HITS       = 64;
	localparam int FILL_COUNT     = SLOTS + 2;
	localparam int MIXED_COUNT    = 87;

	localparam logic [OP_W-1:0] OP_SPARE0 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE1 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE2 = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [TYPE_W-1:0]    ev_type;
		logic [HANDLER_W-1:0] handler;
		logic [SLOT_IN_W-1:0] slot;
	} command_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [HANDLER_W-1:0]  handler;
		logic                  last;
	} notice_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic [OP_W-1:0]       operation  = OP_REGISTER;
	logic [TYPE_W-1:0]     event_type = '0;
	logic [HANDLER_W-1:0]  handler_id = '0;
	logic [SLOT_IN_W-1:0]  slot_in    = '0;
	logic                  busy;
	logic                  strobe;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [HANDLER_W-1:0]  handler_out;
	logic                  last;

	event_subscription_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.event_type(event_type),
		.handler_id(handler_id),
		.slot_in(slot_in),
		.strobe(strobe),
		.status(status),
		.slot_out(slot_out),
		.handler_out(handler_out),
		.last(last)
	);

	always #6 clk = ~clk;

	command_t pending_cmds[$];
	notice_t  expected_notices[$];

	// shadow subscription table
	bit                   sub_valid[SLOTS];
	bit                   sub_enabled[SLOTS];
	logic [TYPE_W-1:0]    sub_type[SLOTS];
	logic [HANDLER_W-1:0] sub_handler[SLOTS];

	int       fail_count      = 0;
	int       cmd_count       = 0;
	int       notice_count    = 0;
	int       full_count      = 0;
	int       widest_dispatch = 0;
	int       driven_count    = 0;
	int       quiet_cycles    = 0;
	bit       took            = 1'b0;
	command_t next_cmd;
	command_t seen_cmd;
	notice_t  want_notice;

	task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [TYPE_W-1:0] ty,
			input logic [HANDLER_W-1:0] hd, input logic [SLOT_IN_W-1:0] sl);
		command_t c;
		c.op      = op;
		c.ev_type = ty;
		c.handler = hd;
		c.slot    = sl;
		pending_cmds.push_back(c);
	endtask

	// update the shadow table and queue the results one command causes
	task automatic apply_command(input command_t c);
		notice_t n;
		int      hits;
		bit      found;
		n      = '0;
		n.last = 1'b1;
		hits   = 0;
		found  = 1'b0;
		case (c.op)
			OP_REGISTER: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !sub_valid[i]) begin
						found          = 1'b1;
						sub_valid[i]   = 1'b1;
						sub_enabled[i] = 1'b1;
						sub_type[i]    = c.ev_type;
						sub_handler[i] = c.handler;
						n.slot         = i[SLOT_OUT_W-1:0];
					end
				end
				n.status = found ? ST_OK : ST_FULL;
				if (!found)
					full_count++;
				expected_notices.push_back(n);
			end
			OP_DELETE, OP_ENABLE, OP_DISABLE: begin
				n.slot = c.slot;
				if (int'(c.slot) >= SLOTS || !sub_valid[c.slot]) begin
					n.status = ST_UNKNOWN;
				end else begin
					n.status = ST_OK;
					if (c.op == OP_DELETE) begin
						sub_valid[c.slot]   = 1'b0;
						sub_enabled[c.slot] = 1'b0;
					end else begin
						sub_enabled[c.slot] = (c.op == OP_ENABLE);
					end
				end
				expected_notices.push_back(n);
			end
			OP_DISPATCH: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (hits < MAX_HITS && sub_valid[i] && sub_enabled[i]
							&& sub_type[i] == c.ev_type) begin
						n.status  = ST_OK;
						n.slot    = i[SLOT_OUT_W-1:0];
						n.handler = sub_handler[i];
						n.last    = 1'b0;
						expected_notices.push_back(n);
						hits++;
					end
				end
				if (hits == 0) begin
					n.status = ST_NOMATCH;
					expected_notices.push_back(n);
				end else begin
					expected_notices[expected_notices.size()-1].last = 1'b1;
				end
				if (hits > widest_dispatch)
					widest_dispatch = hits;
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// driver: new command on the falling edge once the previous one transferred
	always @(negedge clk) begin
		if (arst_n && !(start && !took)) begin
			if (pending_cmds.size() != 0 && !((driven_count < 90 || driven_count >= 150)
					&& $urandom_range(99) < IDLE_PCT)) begin
				next_cmd = pending_cmds.pop_front();
				operation  <= next_cmd.op;
				event_type <= next_cmd.ev_type;
				handler_id <= next_cmd.handler;
				slot_in    <= next_cmd.slot;
				start      <= 1'b1;
				driven_count++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check strobed results, predict on each command transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				notice_count++;
				if (expected_notices.size() == 0) begin
					$error("unexpected result: status %0d slot %0d handler %0h last %0b",
						status, slot_out, handler_out, last);
					fail_count++;
				end else begin
					want_notice = expected_notices.pop_front();
					check_field("status", 16'(want_notice.status), 16'(status));
					check_field("slot_out", 16'(want_notice.slot), 16'(slot_out));
					check_field("handler_out", want_notice.handler, handler_out);
					check_field("last", 16'(want_notice.last), 16'(last));
				end
			end
			if (start && !busy) begin
				seen_cmd.op      = operation;
				seen_cmd.ev_type = event_type;
				seen_cmd.handler = handler_id;
				seen_cmd.slot    = slot_in;
				apply_command(seen_cmd);
				cmd_count++;
			end
			took <= start && !busy;
			if (strobe || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		logic [TYPE_W-1:0] fill_type;
		logic [TYPE_W-1:0] type_pool[3];
		logic [TYPE_W-1:0] ty;
		logic [OP_W-1:0]   op;
		int                pick;

		// directed: empty table, extremes, state changes, reuse, spare codes
		queue_cmd(OP_DISPATCH, 16'h1234, 16'h0000, 6'd0);
		queue_cmd(OP_DELETE,   16'h0000, 16'h0000, 6'd0);
		queue_cmd(OP_ENABLE,   16'hffff, 16'hffff, 6'd63);
		queue_cmd(OP_DISABLE,  16'h0000, 16'h0000, 6'd5);
		queue_cmd(OP_REGISTER, 16'h0000, 16'hffff, 6'd63);
		queue_cmd(OP_REGISTER, 16'hffff, 16'h0000, 6'd0);
		queue_cmd(OP_REGISTER, 16'hffff, 16'ha5a5, 6'd0);
		queue_cmd(OP_DISPATCH, 16'hffff, 16'h0000, 6'd0);
		queue_cmd(OP_DISPATCH, 16'h0000, 16'hffff, 6'd63);
		queue_cmd(OP_DISABLE,  16'h0000, 16'h0000, 6'd1);
		queue_cmd(OP_DISPATCH, 16'hffff, 16'h0000, 6'd0);
		queue_cmd(OP_ENABLE,   16'h0000, 16'h0000, 6'd1);
		queue_cmd(OP_ENABLE,   16'h0000, 16'h0000, 6'd2);
		queue_cmd(OP_DISPATCH, 16'hffff, 16'h0000, 6'd0);
		queue_cmd(OP_DELETE,   16'h0000, 16'h0000, 6'd0);
		queue_cmd(OP_REGISTER, 16'h5a5a, 16'h0001, 6'd0);
		queue_cmd(OP_DELETE,   16'h0000, 16'h0000, 6'd0);
		queue_cmd(OP_DELETE,   16'h0000, 16'h0000, 6'd0);
		queue_cmd(OP_DISABLE,  16'h0000, 16'h0000, 6'd2);
		queue_cmd(OP_DELETE,   16'h0000, 16'h0000, 6'd1);
		queue_cmd(OP_DELETE,   16'h0000, 16'h0000, 6'd2);
		queue_cmd(OP_SPARE0,   16'hffff, 16'hffff, 6'd63);
		queue_cmd(OP_SPARE1,   16'h0000, 16'h0000, 6'd0);
		queue_cmd(OP_SPARE2,   16'hffff, 16'hffff, 6'd0);
		queue_cmd(OP_DISPATCH, 16'hffff, 16'h0000, 6'd0);

		// fill the whole table with one type, overflow it, dispatch everything
		fill_type = 16'($urandom);
		for (int i = 0; i < FILL_COUNT; i++)
			queue_cmd(OP_REGISTER, fill_type, 16'($urandom), 6'($urandom));
		queue_cmd(OP_DISPATCH, fill_type, 16'($urandom), 6'($urandom));
		queue_cmd(OP_DISPATCH, ~fill_type, 16'($urandom), 6'($urandom));

		// mixed traffic on a small set of types so dispatches hit often
		type_pool[0] = fill_type;
		type_pool[1] = 16'($urandom);
		type_pool[2] = 16'($urandom);
		for (int i = 0; i < MIXED_COUNT; i++) begin
			pick = $urandom_range(99);
			if (pick < 25)
				op = OP_REGISTER;
			else if (pick < 45)
				op = OP_DELETE;
			else if (pick < 58)
				op = OP_ENABLE;
			else if (pick < 71)
				op = OP_DISABLE;
			else if (pick < 97)
				op = OP_DISPATCH;
			else
				op = OP_SPARE0 + 3'($urandom_range(2));
			if ($urandom_range(99) < 70)
				ty = type_pool[$urandom_range(2)];
			else
				ty = 16'($urandom);
			queue_cmd(op, ty, 16'($urandom), 6'($urandom_range(SLOTS - 1)));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start || expected_notices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d results, table full seen %0d times,",
			cmd_count, notice_count, full_count);
		$display("widest dispatch fanned out to %0d subscribers", widest_dispatch);
		if (fail_count == 0 && expected_notices.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/est_pkg.sv
src/est_ram.sv
src/est_flags.sv
src/est_ctrl.sv
src/event_subscription_table.sv
src/est_checker.sv
dv/event_subscription_table_tb.sv
